// ----- src/cbh_pkg.sv -----
// Package for the character bigram histogram: sizes, mode codes, the
// controller/datapath command and status structs, and the byte classifier.
// No dependencies; every other file of the block uses it by scoped names.
package cbh_pkg;

  localparam int COUNT_WIDTH  = 32;
  localparam int TOTAL_WIDTH  = 48;
  localparam int CHARSET_SIZE = 88;
  localparam int NUM_CLASSES  = CHARSET_SIZE + 1;
  localparam int CLASS_W      = $clog2(NUM_CLASSES);
  localparam int PAIR_DEPTH   = NUM_CLASSES * NUM_CLASSES;
  localparam int PAIR_AW      = $clog2(PAIR_DEPTH);

  localparam logic [CLASS_W-1:0] CLASS_NUL   = CLASS_W'(CHARSET_SIZE - 1);
  localparam logic [CLASS_W-1:0] CLASS_OTHER = CLASS_W'(CHARSET_SIZE);
  localparam logic [CLASS_W-1:0] CLASS_LIMIT = CLASS_W'(NUM_CLASSES);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  // Input packing.
  localparam int IN_DATA_W = 24;
  localparam int IN_USER_W = 3;
  // Output packing.
  localparam int OUT_DATA_W = 3 * COUNT_WIDTH + 2 * TOTAL_WIDTH;

  typedef enum logic [1:0] {
    MODE_COUNT      = 2'd0,
    MODE_READ_FIRST = 2'd1,
    MODE_READ_PAIR  = 2'd2,
    MODE_READ_TOTAL = 2'd3
  } mode_t;

  typedef struct packed {
    logic clear;   // clearing pass: write zero at the sweep counter
    logic load;    // input item accepted: capture its fields
    logic calc;    // form the table addresses
    logic fetch;   // read both tables
    logic commit;  // write back the count or load the result register
  } cbh_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_count;
    logic out_busy;
  } cbh_status_t;

  // Maps a raw byte to its class: charset position, NUL class or other.
  function automatic logic [CLASS_W-1:0] classify(input logic [7:0] sym);
    logic [CLASS_W-1:0] c;
    c = CLASS_OTHER;
    if (sym >= 8'h61 && sym <= 8'h7A) begin
      c = CLASS_W'(sym - 8'h61);
    end else if (sym >= 8'h41 && sym <= 8'h5A) begin
      c = CLASS_W'(sym - 8'h41 + 8'd26);
    end else if (sym >= 8'h30 && sym <= 8'h39) begin
      c = CLASS_W'(sym - 8'h30 + 8'd52);
    end else begin
      unique case (sym)
        8'h7E:   c = CLASS_W'(62);  // ~
        8'h21:   c = CLASS_W'(63);  // !
        8'h7B:   c = CLASS_W'(64);  // {
        8'h7D:   c = CLASS_W'(65);  // }
        8'h40:   c = CLASS_W'(66);  // @
        8'h23:   c = CLASS_W'(67);  // #
        8'h24:   c = CLASS_W'(68);  // $
        8'h25:   c = CLASS_W'(69);  // %
        8'h5E:   c = CLASS_W'(70);  // ^
        8'h26:   c = CLASS_W'(71);  // &
        8'h2A:   c = CLASS_W'(72);  // *
        8'h28:   c = CLASS_W'(73);  // (
        8'h29:   c = CLASS_W'(74);  // )
        8'h2D:   c = CLASS_W'(75);  // -
        8'h2B:   c = CLASS_W'(76);  // +
        8'h5B:   c = CLASS_W'(77);  // [
        8'h5D:   c = CLASS_W'(78);  // ]
        8'h7C:   c = CLASS_W'(79);  // |
        8'h5C:   c = CLASS_W'(80);  // backslash
        8'h3B:   c = CLASS_W'(81);  // ;
        8'h27:   c = CLASS_W'(82);  // quote
        8'h3A:   c = CLASS_W'(83);  // :
        8'h2C:   c = CLASS_W'(84);  // ,
        8'h2E:   c = CLASS_W'(85);  // .
        8'h2F:   c = CLASS_W'(86);  // /
        8'h00:   c = CLASS_NUL;
        default: c = CLASS_OTHER;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- src/char_bigram_histogram.sv -----
// Top level of the character bigram histogram: controller and datapath.
// Depends on cbh_pkg, cbh_ctrl and cbh_datapath.
//
//  channel | dir | tdata fields (low bit up)               | tuser (low bit up)
//  s_axis  | in  | symbol[7:0], row_class[14:8],           | mode[1:0],
//          |     | col_class[21:15], zero pad              | word_start[2]
//  m_axis  | out | entry_count[31:0], first_total[79:32],  | none
//          |     | first_max[111:80], pair_total[159:112], |
//          |     | pair_max[191:160]                       |
//
// After reset a clearing pass writes zeros over both count tables, with
// s_axis_tready low. Each item then goes through capture, address, table
// read and write-back before the next acceptance, a sequence set by the
// read-modify-write of the count memories. A read result is registered and
// shows on m_axis in the cycle after its commit; while it waits, the next item
// is taken, and a later read result stalls in its commit step until the
// output register is free. Counting items produce no result.
module char_bigram_histogram (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cbh_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // symbol, row_class, col_class
  input  logic [cbh_pkg::IN_USER_W-1:0]     s_axis_tuser,  // mode, word_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // entry_count, first_total, first_max, pair_total, pair_max
  output logic [cbh_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  cbh_pkg::cbh_cmd_t    cmd;
  cbh_pkg::cbh_status_t status;

  cbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cbh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- src/cbh_ctrl.sv -----
// Controller of the bigram histogram: clearing pass after reset, then one
// item at a time through address, fetch and commit steps.
// Depends on cbh_pkg for the command and status structs.
module cbh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cbh_pkg::cbh_status_t status,
  output cbh_pkg::cbh_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_FETCH,
    ST_COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   commit_ok;

  assign accept    = in_valid && in_ready;
  assign commit_ok = status.is_count || !status.out_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_COMMIT;
      ST_COMMIT: if (commit_ok) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.clear  = (state == ST_CLEAR);
    cmd.load   = accept;
    cmd.calc   = (state == ST_ADDR);
    cmd.fetch  = (state == ST_FETCH);
    cmd.commit = (state == ST_COMMIT) && commit_ok;
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_accept_to_addr: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_ADDR)
    else $error("accepted item did not start address step");

  a_commit_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && !status.is_count && status.out_busy) |=> state == ST_COMMIT)
    else $error("read result dropped while output register full");

endmodule

// ----- src/cbh_datapath.sv -----
// Datapath of the bigram histogram: field capture, classifier, address
// arithmetic, both count tables, totals and maxima, and the result register.
// Depends on cbh_pkg; driven by cbh_ctrl through cbh_cmd_t.
module cbh_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cbh_pkg::cbh_cmd_t                   cmd,
  output cbh_pkg::cbh_status_t                status,
  input  logic [cbh_pkg::IN_DATA_W-1:0]       in_data,
  input  logic [cbh_pkg::IN_USER_W-1:0]       in_user,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbh_pkg::OUT_DATA_W-1:0]      out_data
);

  localparam int CW = cbh_pkg::CLASS_W;
  localparam int NW = cbh_pkg::COUNT_WIDTH;
  localparam int TW = cbh_pkg::TOTAL_WIDTH;
  localparam int AW = cbh_pkg::PAIR_AW;
  localparam logic [AW-1:0] PAIR_LAST = AW'(cbh_pkg::PAIR_DEPTH - 1);
  localparam logic [AW-1:0] FIRST_END = AW'(cbh_pkg::NUM_CLASSES);

  // Captured item.
  cbh_pkg::mode_t mode;
  logic           start;
  logic [CW-1:0]  cls;
  logic [CW-1:0]  row;
  logic [CW-1:0]  col;

  // Running state.
  logic [CW-1:0]  prev_cls;
  logic [TW-1:0]  first_sum;
  logic [NW-1:0]  first_peak;
  logic [TW-1:0]  pair_sum;
  logic [NW-1:0]  pair_peak;

  // Addressing and table read data.
  logic [CW-1:0]  first_addr;
  logic [AW-1:0]  pair_addr;
  logic           in_range;
  logic [NW-1:0]  rd_first;
  logic [NW-1:0]  rd_pair;
  logic [AW-1:0]  clr_cnt;

  logic [NW-1:0]  first_mem [cbh_pkg::NUM_CLASSES];
  logic [NW-1:0]  pair_mem  [cbh_pkg::PAIR_DEPTH];

  // Result register.
  logic [NW-1:0]  res_entry;
  logic [TW-1:0]  res_first_total;
  logic [NW-1:0]  res_first_max;
  logic [TW-1:0]  res_pair_total;
  logic [NW-1:0]  res_pair_max;

  logic [CW-1:0]   addr_row;
  logic [CW-1:0]   addr_col;
  logic            range_next;
  logic [2*CW-1:0] pair_prod;
  logic            row_ok;
  logic            col_ok;

  logic            first_hit;
  logic            pair_hit;
  logic [NW-1:0]   first_new;
  logic [NW-1:0]   pair_new;
  logic            do_first;
  logic            do_pair;
  logic            first_we;
  logic [CW-1:0]   first_wa;
  logic [NW-1:0]   first_wd;
  logic            pair_we;
  logic [AW-1:0]   pair_wa;
  logic [NW-1:0]   pair_wd;
  logic [NW-1:0]   entry_sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode  <= cbh_pkg::mode_t'(in_user[1:0]);
      start <= in_user[2];
      cls   <= cbh_pkg::classify(in_data[7:0]);
      row   <= in_data[8 +: CW];
      col   <= in_data[8 + CW +: CW];
    end
  end

  // Counting uses previous/current class; reads use the row/column asked for.
  assign row_ok = row < cbh_pkg::CLASS_LIMIT;
  assign col_ok = col < cbh_pkg::CLASS_LIMIT;

  always_comb begin
    addr_row   = '0;
    addr_col   = '0;
    range_next = 1'b0;
    unique case (mode)
      cbh_pkg::MODE_COUNT: begin
        addr_row   = prev_cls;
        addr_col   = cls;
        range_next = 1'b1;
      end
      cbh_pkg::MODE_READ_FIRST: begin
        range_next = row_ok;
        if (row_ok) addr_row = row;
      end
      cbh_pkg::MODE_READ_PAIR: begin
        range_next = row_ok && col_ok;
        if (row_ok && col_ok) begin
          addr_row = row;
          addr_col = col;
        end
      end
      cbh_pkg::MODE_READ_TOTAL: begin
        range_next = 1'b0;
      end
      default: range_next = 1'b0;
    endcase
  end

  assign pair_prod = (2*CW)'(addr_row) * (2*CW)'(cbh_pkg::NUM_CLASSES);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      // A count addresses the first table with its own class.
      first_addr <= (mode == cbh_pkg::MODE_COUNT) ? cls : addr_row;
      pair_addr  <= AW'(pair_prod + (2*CW)'(addr_col));
      in_range   <= range_next;
    end
  end

  assign first_hit = rd_first != cbh_pkg::COUNT_MAX;
  assign pair_hit  = rd_pair != cbh_pkg::COUNT_MAX;
  assign first_new = rd_first + NW'(1);
  assign pair_new  = rd_pair + NW'(1);
  assign do_first  = cmd.commit && (mode == cbh_pkg::MODE_COUNT) && start && first_hit;
  assign do_pair   = cmd.commit && (mode == cbh_pkg::MODE_COUNT) && !start && pair_hit;

  always_comb begin
    first_we = do_first;
    first_wa = first_addr;
    first_wd = first_new;
    pair_we  = do_pair;
    pair_wa  = pair_addr;
    pair_wd  = pair_new;
    if (cmd.clear) begin
      first_we = clr_cnt < FIRST_END;
      first_wa = clr_cnt[CW-1:0];
      first_wd = '0;
      pair_we  = 1'b1;
      pair_wa  = clr_cnt;
      pair_wd  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    if (cmd.fetch) rd_first <= first_mem[first_addr];
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_wa] <= pair_wd;
    if (cmd.fetch) rd_pair <= pair_mem[pair_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Totals and maxima ignore the unknown-byte class on either side of a pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cls   <= '0;
      first_sum  <= '0;
      first_peak <= '0;
      pair_sum   <= '0;
      pair_peak  <= '0;
    end else begin
      if (cmd.commit && mode == cbh_pkg::MODE_COUNT) begin
        prev_cls <= cls;
      end
      if (do_first && cls != cbh_pkg::CLASS_OTHER) begin
        if (first_sum != cbh_pkg::TOTAL_MAX) first_sum <= first_sum + TW'(1);
        if (first_new > first_peak) first_peak <= first_new;
      end
      if (do_pair && cls != cbh_pkg::CLASS_OTHER && prev_cls != cbh_pkg::CLASS_OTHER) begin
        if (pair_sum != cbh_pkg::TOTAL_MAX) pair_sum <= pair_sum + TW'(1);
        if (pair_new > pair_peak) pair_peak <= pair_new;
      end
    end
  end

  always_comb begin
    entry_sel = '0;
    if (in_range) begin
      entry_sel = (mode == cbh_pkg::MODE_READ_PAIR) ? rd_pair : rd_first;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mode != cbh_pkg::MODE_COUNT) begin
      res_entry       <= entry_sel;
      res_first_total <= (mode == cbh_pkg::MODE_READ_TOTAL) ? first_sum  : '0;
      res_first_max   <= (mode == cbh_pkg::MODE_READ_TOTAL) ? first_peak : '0;
      res_pair_total  <= (mode == cbh_pkg::MODE_READ_TOTAL) ? pair_sum   : '0;
      res_pair_max    <= (mode == cbh_pkg::MODE_READ_TOTAL) ? pair_peak  : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && mode != cbh_pkg::MODE_COUNT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {res_pair_max, res_pair_total, res_first_max, res_first_total, res_entry};

  assign status.clear_last = clr_cnt == PAIR_LAST;
  assign status.is_count   = mode == cbh_pkg::MODE_COUNT;
  assign status.out_busy   = out_valid && !out_ready;

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  a_pair_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> pair_sum >= $past(pair_sum))
    else $error("pair total decreased");

  a_no_commit_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.commit && !cmd.load)
    else $error("item handled during clearing pass");

endmodule
